### design/two_choice_block_linear_probe_table_core_macros.svh
// Assertion macros shared by the table core RTL
`ifndef TWO_CHOICE_BLOCK_LINEAR_PROBE_TABLE_CORE_MACROS_SVH
`define TWO_CHOICE_BLOCK_LINEAR_PROBE_TABLE_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define TCB_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, clocked on clk, quiet in reset
`define TCB_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### design/tcblp_pkg.sv
// Types and constants for the two-choice blocked linear probing table
package tcblp_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int AW        = $clog2(MAX_SLOTS);
  localparam int SZ_W      = $clog2(MAX_SLOTS + 1);
  localparam int CFG_W     = 11;
  localparam int KEY_W     = 64;
  localparam int PC_W      = 12;
  localparam int CNT_W     = $clog2(KEY_W + 1);

  localparam logic [1:0] REG_TABLE_SLOTS = 2'd0;
  localparam logic [1:0] REG_BLOCK_SLOTS = 2'd1;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [KEY_W-1:0] hash_a;
    logic [KEY_W-1:0] hash_b;
    logic             coin;
  } in_item_t;

  typedef struct packed {
    logic             success;
    logic [PC_W-1:0]  probe_count;
    logic [CFG_W-1:0] stored_count;
  } out_item_t;

  typedef struct packed {
    logic             go;
    logic             short_op;
    logic [KEY_W-1:0] dividend;
    logic [SZ_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [AW-1:0] quo;
    logic [AW-1:0] rem;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_HA,
    ST_HB,
    ST_DA,
    ST_DB,
    ST_SMP,
    ST_SMQ,
    ST_LD1,
    ST_LD2,
    ST_CHS,
    ST_IBLK,
    ST_IBLKW,
    ST_IMOD,
    ST_IPRB,
    ST_IPRBW,
    ST_SSEL,
    ST_SPRBW,
    ST_FIN
  } state_t;

endpackage

### design/tcblp_div.sv
// Shared restoring divider, one quotient bit per cycle
module tcblp_div (
  input  logic                clk,
  input  logic                rst,
  input  tcblp_pkg::div_req_t req,
  output tcblp_pkg::div_rsp_t rsp
);
  import tcblp_pkg::*;

  logic [KEY_W-1:0] shreg;
  logic [AW-1:0]    rem;
  logic [SZ_W-1:0]  dvs;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;
  logic [AW:0]      trial;
  logic             fits;

  assign trial = {rem, shreg[KEY_W-1]};
  assign fits  = trial >= dvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
        cnt <= req.short_op ? CNT_W'(AW) : CNT_W'(KEY_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      shreg <= req.short_op ? {req.dividend[AW-1:0], {(KEY_W-AW){1'b0}}} : req.dividend;
      rem   <= '0;
      dvs   <= req.divisor;
    end else if (run) begin
      shreg <= {shreg[KEY_W-2:0], fits};
      rem   <= fits ? AW'(trial - dvs) : trial[AW-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = shreg[AW-1:0];
  assign rsp.rem  = rem;

endmodule

### design/two_choice_block_linear_probe_table_core.sv
// Top level of the two-choice blocked linear probing key table
//
//   channel   ports                            handshake
//   command   start, item                      taken when start && !busy
//   result    done, result                     one-cycle strobe, no back-pressure
//   config    cfg_we, cfg_idx, cfg_data        taken when cfg_we
//
// Before probing, a command runs two 64-step hash reductions and two 10-step block splits,
// all on the one shared divider, plus the start-offset folds on the same divider.
// Each slot probe then goes through the registered slot memory read.
// Reset and every write to table_slots or block_slots start a clearing pass over slot
// and load memories; busy stays high through it. Results cannot be stalled.
`include "two_choice_block_linear_probe_table_core_macros.svh"

module two_choice_block_linear_probe_table_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  tcblp_pkg::in_item_t   item,
  output logic                  done,
  output tcblp_pkg::out_item_t  result,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [tcblp_pkg::CFG_W-1:0] cfg_data
);
  import tcblp_pkg::*;

  function automatic logic [SZ_W-1:0] blen(input logic [AW-1:0] base,
                                           input logic [SZ_W-1:0] sz,
                                           input logic [SZ_W-1:0] b);
    logic [SZ_W-1:0] rest;
    rest = sz - SZ_W'(base);
    return (rest < b) ? rest : b;
  endfunction

  logic [CFG_W-1:0] table_slots, block_slots;
  logic [SZ_W-1:0]  size, bs;
  logic             cfg_hit;

  state_t state, state_next;
  logic [KEY_W-1:0] key_r, key_next, hb_r, hb_next;
  logic             kind_r, kind_next, coin_r, coin_next;
  logic [AW-1:0]    h1, h1_next, h2, h2_next, b1, b1_next, b2, b2_next, o1, o1_next;
  logic [AW-1:0]    o2, o2_next;
  logic [SZ_W-1:0]  l1, l1_next, ld, ld_next;
  logic [AW-1:0]    p_base, p_base_next, p_blk, p_blk_next, p_off, p_off_next;
  logic [AW-1:0]    p_idx, p_idx_next, p_cnt, p_cnt_next;
  logic [AW-1:0]    q_base, q_base_next, q_blk, q_blk_next, q_idx, q_idx_next;
  logic [AW-1:0]    q_cnt, q_cnt_next, home, home_next;
  logic             jump0, jump0_next, turn, turn_next;
  logic             pd, pd_next, qd, qd_next, pf, pf_next, qf, qf_next;
  logic             ok_r, ok_next;
  logic [PC_W-1:0]  probes, probes_next;
  logic [SZ_W-1:0]  key_total, key_total_next;
  logic [AW-1:0]    clr_idx, clr_idx_next;
  logic             done_next;
  out_item_t        result_next;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [KEY_W:0]   slot_mem [MAX_SLOTS];
  logic [KEY_W:0]   slot_q, slot_wdata;
  logic [AW-1:0]    slot_raddr, slot_waddr;
  logic             slot_we;
  logic [SZ_W-1:0]  load_mem [MAX_SLOTS];
  logic [SZ_W-1:0]  load_q, load_wdata;
  logic [AW-1:0]    load_raddr, load_waddr;
  logic             load_we;

  logic [AW-1:0]    base1, base2, p_pos, q_pos, p_nbase, q_nbase, p_nblk, q_nblk;
  logic [AW-1:0]    p_idx_inc, q_idx_inc;
  logic [SZ_W-1:0]  len1, len2, lenp, lenq, p_nb_raw, q_nb_raw;
  logic             p_wrap, q_wrap, p_last, q_last, hit, f1, f2, first;

  tcblp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    if (table_slots == '0) begin
      size = SZ_W'(1);
    end else if (table_slots > SZ_W'(MAX_SLOTS)) begin
      size = SZ_W'(MAX_SLOTS);
    end else begin
      size = table_slots;
    end
    if (block_slots == '0) begin
      bs = SZ_W'(1);
    end else if (block_slots > size) begin
      bs = size;
    end else begin
      bs = block_slots;
    end
  end

  assign cfg_hit = cfg_we && (cfg_idx == REG_TABLE_SLOTS || cfg_idx == REG_BLOCK_SLOTS);

  assign base1     = h1 - o1;
  assign base2     = h2 - o2;
  assign len1      = blen(base1, size, bs);
  assign len2      = blen(base2, size, bs);
  assign lenp      = blen(p_base, size, bs);
  assign lenq      = blen(q_base, size, bs);
  assign p_pos     = p_base + p_idx;
  assign q_pos     = q_base + q_idx;
  assign p_nb_raw  = SZ_W'(p_base) + bs;
  assign q_nb_raw  = SZ_W'(q_base) + bs;
  assign p_wrap    = p_nb_raw >= size;
  assign q_wrap    = q_nb_raw >= size;
  assign p_nbase   = p_wrap ? '0 : p_nb_raw[AW-1:0];
  assign q_nbase   = q_wrap ? '0 : q_nb_raw[AW-1:0];
  assign p_nblk    = p_wrap ? '0 : p_blk + 1'b1;
  assign q_nblk    = q_wrap ? '0 : q_blk + 1'b1;
  assign p_idx_inc = (SZ_W'(p_idx) + 1'b1 == lenp) ? '0 : p_idx + 1'b1;
  assign q_idx_inc = (SZ_W'(q_idx) + 1'b1 == lenq) ? '0 : q_idx + 1'b1;
  assign p_last    = SZ_W'(p_cnt) + 1'b1 == lenp;
  assign q_last    = SZ_W'(q_cnt) + 1'b1 == lenq;
  assign hit       = slot_q[KEY_W] && (slot_q[KEY_W-1:0] == key_r);

  assign f1    = l1 >= len1;
  assign f2    = load_q >= len2;
  assign first = (f1 && !f2) ? 1'b0 :
                 (f2 && !f1) ? 1'b1 :
                 (l1 < load_q) ? 1'b1 :
                 (load_q < l1) ? 1'b0 : coin_r;

  assign slot_raddr = turn ? q_pos : p_pos;

  always_comb begin
    unique case (state)
      ST_LD1:  load_raddr = b1;
      ST_LD2:  load_raddr = b2;
      default: load_raddr = p_blk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      load_mem[load_waddr] <= load_wdata;
    end
    load_q <= load_mem[load_raddr];
  end

  always_comb begin
    state_next     = state;
    key_next       = key_r;
    hb_next        = hb_r;
    kind_next      = kind_r;
    coin_next      = coin_r;
    h1_next        = h1;
    h2_next        = h2;
    b1_next        = b1;
    b2_next        = b2;
    o1_next        = o1;
    o2_next        = o2;
    l1_next        = l1;
    ld_next        = ld;
    p_base_next    = p_base;
    p_blk_next     = p_blk;
    p_off_next     = p_off;
    p_idx_next     = p_idx;
    p_cnt_next     = p_cnt;
    q_base_next    = q_base;
    q_blk_next     = q_blk;
    q_idx_next     = q_idx;
    q_cnt_next     = q_cnt;
    home_next      = home;
    jump0_next     = jump0;
    turn_next      = turn;
    pd_next        = pd;
    qd_next        = qd;
    pf_next        = pf;
    qf_next        = qf;
    ok_next        = ok_r;
    probes_next    = probes;
    key_total_next = key_total;
    clr_idx_next   = clr_idx;
    done_next      = 1'b0;
    result_next    = result;
    div_req        = '0;
    slot_we        = 1'b0;
    slot_waddr     = p_pos;
    slot_wdata     = {1'b1, key_r};
    load_we        = 1'b0;
    load_waddr     = p_blk;
    load_wdata     = ld + 1'b1;

    unique case (state)
      ST_CLR: begin
        slot_we      = 1'b1;
        slot_waddr   = clr_idx;
        slot_wdata   = '0;
        load_we      = 1'b1;
        load_waddr   = clr_idx;
        load_wdata   = '0;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == AW'(MAX_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          probes_next = '0;
          key_next    = item.key;
          hb_next     = item.hash_b;
          kind_next   = item.kind;
          coin_next   = item.coin;
          if (item.kind == OP_INSERT && key_total >= size) begin
            ok_next    = 1'b0;
            state_next = ST_FIN;
          end else begin
            div_req.go       = 1'b1;
            div_req.dividend = item.hash_a;
            div_req.divisor  = size;
            state_next       = ST_HA;
          end
        end
      end
      ST_HA: begin
        if (div_rsp.done) begin
          h1_next          = div_rsp.rem;
          div_req.go       = 1'b1;
          div_req.dividend = hb_r;
          div_req.divisor  = size;
          state_next       = ST_HB;
        end
      end
      ST_HB: begin
        if (div_rsp.done) begin
          h2_next          = div_rsp.rem;
          div_req.go       = 1'b1;
          div_req.short_op = 1'b1;
          div_req.dividend = KEY_W'(h1);
          div_req.divisor  = bs;
          state_next       = ST_DA;
        end
      end
      ST_DA: begin
        if (div_rsp.done) begin
          b1_next          = div_rsp.quo;
          o1_next          = div_rsp.rem;
          div_req.go       = 1'b1;
          div_req.short_op = 1'b1;
          div_req.dividend = KEY_W'(h2);
          div_req.divisor  = bs;
          state_next       = ST_DB;
        end
      end
      ST_DB: begin
        if (div_rsp.done) begin
          b2_next = div_rsp.quo;
          o2_next = div_rsp.rem;
          if (kind_r == OP_INSERT) begin
            state_next = ST_LD1;
          end else begin
            p_base_next      = base1;
            p_blk_next       = b1;
            home_next        = base1;
            q_base_next      = h2 - div_rsp.rem;
            q_blk_next       = div_rsp.quo;
            div_req.go       = 1'b1;
            div_req.short_op = 1'b1;
            div_req.dividend = KEY_W'(o1);
            div_req.divisor  = len1;
            state_next       = ST_SMP;
          end
        end
      end
      ST_SMP: begin
        if (div_rsp.done) begin
          p_idx_next       = div_rsp.rem;
          div_req.go       = 1'b1;
          div_req.short_op = 1'b1;
          div_req.dividend = KEY_W'(o2);
          div_req.divisor  = lenq;
          state_next       = ST_SMQ;
        end
      end
      ST_SMQ: begin
        if (div_rsp.done) begin
          q_idx_next = div_rsp.rem;
          p_cnt_next = '0;
          q_cnt_next = '0;
          pd_next    = 1'b0;
          qd_next    = 1'b0;
          pf_next    = 1'b0;
          qf_next    = 1'b0;
          turn_next  = 1'b0;
          state_next = ST_SSEL;
        end
      end
      ST_LD1: begin
        state_next = ST_LD2;
      end
      ST_LD2: begin
        l1_next    = load_q;
        state_next = ST_CHS;
      end
      ST_CHS: begin
        p_base_next = first ? base1 : base2;
        p_blk_next  = first ? b1 : b2;
        p_off_next  = first ? o1 : o2;
        home_next   = first ? base1 : base2;
        jump0_next  = 1'b1;
        turn_next   = 1'b0;
        state_next  = ST_IBLK;
      end
      ST_IBLK: begin
        state_next = ST_IBLKW;
      end
      ST_IBLKW: begin
        ld_next = load_q;
        if (load_q >= lenp) begin
          p_base_next = p_nbase;
          p_blk_next  = p_nblk;
          jump0_next  = 1'b0;
          if (p_nbase == home) begin
            ok_next    = 1'b0;
            state_next = ST_FIN;
          end else begin
            state_next = ST_IBLK;
          end
        end else if (jump0) begin
          div_req.go       = 1'b1;
          div_req.short_op = 1'b1;
          div_req.dividend = KEY_W'(p_off);
          div_req.divisor  = lenp;
          state_next       = ST_IMOD;
        end else begin
          p_idx_next = '0;
          p_cnt_next = '0;
          state_next = ST_IPRB;
        end
      end
      ST_IMOD: begin
        if (div_rsp.done) begin
          p_idx_next = div_rsp.rem;
          p_cnt_next = '0;
          state_next = ST_IPRB;
        end
      end
      ST_IPRB: begin
        state_next = ST_IPRBW;
      end
      ST_IPRBW: begin
        probes_next = probes + 1'b1;
        if (!slot_q[KEY_W]) begin
          slot_we        = 1'b1;
          load_we        = 1'b1;
          key_total_next = key_total + 1'b1;
          ok_next        = 1'b1;
          state_next     = ST_FIN;
        end else if (p_last) begin
          p_base_next = p_nbase;
          p_blk_next  = p_nblk;
          jump0_next  = 1'b0;
          if (p_nbase == home) begin
            ok_next    = 1'b0;
            state_next = ST_FIN;
          end else begin
            state_next = ST_IBLK;
          end
        end else begin
          p_idx_next = p_idx_inc;
          p_cnt_next = p_cnt + 1'b1;
          state_next = ST_IPRB;
        end
      end
      ST_SSEL: begin
        if (pd && qd) begin
          if (pf && qf && p_nbase != home) begin
            p_base_next = p_nbase;
            p_blk_next  = p_nblk;
            q_base_next = q_nbase;
            q_blk_next  = q_nblk;
            p_idx_next  = '0;
            q_idx_next  = '0;
            p_cnt_next  = '0;
            q_cnt_next  = '0;
            pd_next     = 1'b0;
            qd_next     = 1'b0;
            pf_next     = 1'b0;
            qf_next     = 1'b0;
            turn_next   = 1'b0;
          end else begin
            ok_next    = 1'b0;
            state_next = ST_FIN;
          end
        end else if ((!turn && !pd) || (turn && !qd)) begin
          state_next = ST_SPRBW;
        end else begin
          turn_next = !turn;
        end
      end
      ST_SPRBW: begin
        probes_next = probes + 1'b1;
        turn_next   = !turn;
        state_next  = ST_SSEL;
        if (hit) begin
          ok_next    = 1'b1;
          state_next = ST_FIN;
        end else if (!turn) begin
          if (!slot_q[KEY_W]) begin
            pd_next = 1'b1;
          end else if (p_last) begin
            pd_next = 1'b1;
            pf_next = 1'b1;
          end else begin
            p_idx_next = p_idx_inc;
            p_cnt_next = p_cnt + 1'b1;
          end
        end else begin
          if (!slot_q[KEY_W]) begin
            qd_next = 1'b1;
          end else if (q_last) begin
            qd_next = 1'b1;
            qf_next = 1'b1;
          end else begin
            q_idx_next = q_idx_inc;
            q_cnt_next = q_cnt + 1'b1;
          end
        end
      end
      ST_FIN: begin
        done_next                = 1'b1;
        result_next.success      = ok_r;
        result_next.probe_count  = probes;
        result_next.stored_count = key_total;
        state_next               = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_slots <= CFG_W'(1024);
      block_slots <= CFG_W'(16);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_TABLE_SLOTS: table_slots <= cfg_data;
        REG_BLOCK_SLOTS: block_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      state     <= ST_CLR;
      clr_idx   <= '0;
      key_total <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      key_total <= key_total_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_next;
    hb_r   <= hb_next;
    kind_r <= kind_next;
    coin_r <= coin_next;
    h1     <= h1_next;
    h2     <= h2_next;
    b1     <= b1_next;
    b2     <= b2_next;
    o1     <= o1_next;
    o2     <= o2_next;
    l1     <= l1_next;
    ld     <= ld_next;
    p_base <= p_base_next;
    p_blk  <= p_blk_next;
    p_off  <= p_off_next;
    p_idx  <= p_idx_next;
    p_cnt  <= p_cnt_next;
    q_base <= q_base_next;
    q_blk  <= q_blk_next;
    q_idx  <= q_idx_next;
    q_cnt  <= q_cnt_next;
    home   <= home_next;
    jump0  <= jump0_next;
    turn   <= turn_next;
    pd     <= pd_next;
    qd     <= qd_next;
    pf     <= pf_next;
    qf     <= qf_next;
    ok_r   <= ok_next;
    probes <= probes_next;
    result <= result_next;
  end

  assign busy = state != ST_IDLE;

  `TCB_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `TCB_ASSERT_NXT(a_done_single, done, !done, "result strobe lasted more than one cycle")
  `TCB_ASSERT_IMP(a_stored_bound, done, result.stored_count <= CFG_W'(MAX_SLOTS), "stored count over table capacity")

endmodule
